>>> src/pfa_pkg.sv
// shared types and constants of the prime field arithmetic unit
`default_nettype none
package pfa_pkg;

	localparam int FUNC_WIDTH = 3;
	localparam int A_WIDTH    = 32;
	localparam int B_WIDTH    = 21;
	localparam int IN_TDATA_W = 56;
	localparam int FUNC_LSB   = 0;
	localparam int A_LSB      = FUNC_LSB + FUNC_WIDTH;
	localparam int B_LSB      = A_LSB + A_WIDTH;
	localparam int CNT_W      = $clog2(A_WIDTH);
	localparam int STATUS_W   = 2;

	localparam int unsigned MODULUS_RESET = 1234577;

	localparam logic [FUNC_WIDTH-1:0] FUNC_REDUCE = 3'd0;
	localparam logic [FUNC_WIDTH-1:0] FUNC_ADD    = 3'd1;
	localparam logic [FUNC_WIDTH-1:0] FUNC_SUB    = 3'd2;
	localparam logic [FUNC_WIDTH-1:0] FUNC_MUL    = 3'd3;
	localparam logic [FUNC_WIDTH-1:0] FUNC_DIV    = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_DIV_ZERO = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_INV   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED_A,
		ST_FIX_A,
		ST_RED_B,
		ST_DISPATCH,
		ST_SUB_FIX,
		ST_MUL_DBL,
		ST_MUL_ADD,
		ST_INV_WAIT,
		ST_FINISH
	} pfa_state_t;

	typedef enum logic [2:0] {
		INV_IDLE,
		INV_STEP,
		INV_FIX,
		INV_OK,
		INV_FAIL
	} pfa_inv_state_t;

	typedef struct packed {
		logic done;
		logic ok;
	} pfa_inv_stat_t;

endpackage
`default_nettype wire

>>> src/pfa_inverse.sv
// iterative binary extended gcd giving the modular inverse of a divisor
`default_nettype none
module pfa_inverse #(
	parameter int ELEMENT_WIDTH = 21
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  wire [ELEMENT_WIDTH-1:0]  modulus,
	input  wire [ELEMENT_WIDTH-1:0]  divisor,
	output logic [ELEMENT_WIDTH-1:0] inverse,
	output pfa_pkg::pfa_inv_stat_t   stat
);
	import pfa_pkg::*;

	localparam int W  = ELEMENT_WIDTH;
	localparam int CW = ELEMENT_WIDTH + 4;

	pfa_inv_state_t state_q, state_n;

	logic [W-1:0]         u_q, v_q;
	logic signed [CW-1:0] a_q, b_q, c_q, d_q;
	logic signed [CW-1:0] x_ext, y_ext;
	logic signed [CW-1:0] a_sum, b_sum, c_sum, d_sum, d_plus;
	logic                 ab_odd, cd_odd, u_ge_v, d_ge_m;

	assign x_ext = {{(CW-W){1'b0}}, modulus};
	assign y_ext = {{(CW-W){1'b0}}, divisor};

	always_comb begin
		ab_odd = a_q[0] | b_q[0];
		cd_odd = c_q[0] | d_q[0];
		a_sum  = a_q + y_ext;
		b_sum  = b_q - x_ext;
		c_sum  = c_q + y_ext;
		d_sum  = d_q - x_ext;
		d_plus = d_q + x_ext;
		u_ge_v = (u_q >= v_q);
		d_ge_m = (d_q >= x_ext);
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			INV_IDLE: begin
				if (start)
					state_n = (!modulus[0] && !divisor[0]) ? INV_FAIL : INV_STEP;
			end
			INV_STEP: begin
				if (u_q == '0)
					state_n = (v_q == W'(1)) ? INV_FIX : INV_FAIL;
			end
			INV_FIX: begin
				if (!d_q[CW-1] && !d_ge_m)
					state_n = INV_OK;
			end
			INV_OK:   state_n = INV_IDLE;
			INV_FAIL: state_n = INV_IDLE;
			default:  state_n = INV_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		stat.done = (state_q == INV_OK) || (state_q == INV_FAIL);
		stat.ok   = (state_q == INV_OK);
		inverse   = d_q[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= INV_IDLE;
		else
			state_q <= state_n;
	end

	// invariants: a*m + b*divisor = u, c*m + d*divisor = v
	always_ff @(posedge clk) begin
		case (state_q)
			INV_IDLE: begin
				u_q <= modulus;
				v_q <= divisor;
				a_q <= CW'(1);
				b_q <= '0;
				c_q <= '0;
				d_q <= CW'(1);
			end
			INV_STEP: begin
				if (u_q == '0) begin
					u_q <= u_q;
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
					a_q <= ab_odd ? (a_sum >>> 1) : (a_q >>> 1);
					b_q <= ab_odd ? (b_sum >>> 1) : (b_q >>> 1);
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
					c_q <= cd_odd ? (c_sum >>> 1) : (c_q >>> 1);
					d_q <= cd_odd ? (d_sum >>> 1) : (d_q >>> 1);
				end else if (u_ge_v) begin
					u_q <= u_q - v_q;
					a_q <= a_q - c_q;
					b_q <= b_q - d_q;
				end else begin
					v_q <= v_q - u_q;
					c_q <= c_q - a_q;
					d_q <= d_q - b_q;
				end
			end
			INV_FIX: begin
				if (d_q[CW-1])
					d_q <= d_plus;
				else if (d_ge_m)
					d_q <= d_sum;
			end
			default: begin
				d_q <= d_q;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> src/prime_field_arithmetic_unit_top.sv
// top level of the prime field arithmetic unit: sequencer, shared modular step, output register
//
//  channel   dir   handshake            payload
//  s_*       in    s_tvalid/s_tready    s_tdata: func, operand_a, operand_b
//  m_*       out   m_tvalid/m_tready    m_tdata: result, a_equals_b, a_less_b, status
//  cfg_*     in    cfg_valid/cfg_ready  cfg_data: modulus
//
// one item at a time: s_tready is high only while the sequencer is idle
// operand_a and operand_b are reduced a quotient bit a cycle (32 + 21 quotient bits) on the shared
// conditional-subtract unit; subtract then adds a fix step, multiply a double and an add step
// per multiplier bit, divide also the gcd loop for the inverse before its multiply
// reset restores modulus 1234577; modulus zero or one skips the reduction
// a finished beat waits in the output register while the next item is taken
`default_nettype none
module prime_field_arithmetic_unit_top #(
	parameter int ELEMENT_WIDTH = 21
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   s_tvalid,
	output logic                                  s_tready,
	// [2:0] func, [34:3] operand_a, [55:35] operand_b
	input  wire [pfa_pkg::IN_TDATA_W-1:0]         s_tdata,
	output logic                                  m_tvalid,
	input  wire                                   m_tready,
	// [W-1:0] result, [W] a_equals_b, [W+1] a_less_b, [W+3:W+2] status, zero pad
	output logic [((ELEMENT_WIDTH+4+7)/8)*8-1:0]  m_tdata,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire [ELEMENT_WIDTH-1:0]               cfg_data
);
	import pfa_pkg::*;

	localparam int W      = ELEMENT_WIDTH;
	localparam int OUT_W  = ((ELEMENT_WIDTH + 4 + 7) / 8) * 8;
	localparam int IDX_W  = $clog2(ELEMENT_WIDTH);
	localparam int B_PAD  = A_WIDTH - B_WIDTH;
	localparam logic [W-1:0] MOD_RST = W'(MODULUS_RESET);

	pfa_state_t state_q, state_n;

	logic [W-1:0]          m_q;         // modulus register
	logic [FUNC_WIDTH-1:0] func_q;
	logic                  neg_q;       // operand_a was negative
	logic [A_WIDTH-1:0]    div_q;       // dividend bits, msb first
	logic [B_WIDTH-1:0]    b_in_q;
	logic [W-1:0]          rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [W-1:0]          ra_q, rb_q;  // reduced operands
	logic [W-1:0]          acc_q;       // running result
	logic [W-1:0]          x_q;         // multiplier
	logic [STATUS_W-1:0]   status_q;
	logic                  m_tvalid_q;
	logic [OUT_W-1:0]      m_tdata_q;

	// control outputs of the sequencer
	logic accept, inv_start, out_load;

	// shared unit: t mod m for t < 2m
	logic [W:0]   mod_in;
	logic [W+1:0] mod_diff;
	logic [W-1:0] mod_out;

	logic [A_WIDTH-1:0] a_in, a_mag;
	logic [W-1:0]       inv_val;
	pfa_inv_stat_t      inv_stat;
	logic               small_mod;
	logic [OUT_W-1:0]   out_data;

	assign a_in      = s_tdata[A_LSB +: A_WIDTH];
	assign a_mag     = a_in[A_WIDTH-1] ? (~a_in + A_WIDTH'(1)) : a_in;
	assign small_mod = (m_q < W'(2));

	always_comb begin
		case (state_q)
			ST_RED_A, ST_RED_B: mod_in = {rem_q, div_q[A_WIDTH-1]};
			ST_DISPATCH:        mod_in = {1'b0, ra_q} + {1'b0, rb_q};
			ST_MUL_DBL:         mod_in = {acc_q, 1'b0};
			ST_MUL_ADD:         mod_in = {1'b0, acc_q} + {1'b0, ra_q};
			default:            mod_in = '0;
		endcase
		mod_diff = {1'b0, mod_in} - {2'b00, m_q};
		mod_out  = mod_diff[W+1] ? mod_in[W-1:0] : mod_diff[W-1:0];
	end

	pfa_inverse #(
		.ELEMENT_WIDTH(ELEMENT_WIDTH)
	) u_inverse (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (inv_start),
		.modulus (m_q),
		.divisor (rb_q),
		.inverse (inv_val),
		.stat    (inv_stat)
	);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid)
					state_n = small_mod ? ST_FINISH : ST_RED_A;
			end
			ST_RED_A: begin
				if (cnt_q == '0)
					state_n = ST_FIX_A;
			end
			ST_FIX_A: state_n = ST_RED_B;
			ST_RED_B: begin
				if (cnt_q == '0)
					state_n = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				case (func_q)
					FUNC_SUB: state_n = ST_SUB_FIX;
					FUNC_MUL: state_n = ST_MUL_DBL;
					FUNC_DIV: state_n = (rb_q == '0) ? ST_FINISH : ST_INV_WAIT;
					default:  state_n = ST_FINISH;
				endcase
			end
			ST_SUB_FIX: state_n = ST_FINISH;
			ST_MUL_DBL: state_n = ST_MUL_ADD;
			ST_MUL_ADD: begin
				state_n = (cnt_q == '0) ? ST_FINISH : ST_MUL_DBL;
			end
			ST_INV_WAIT: begin
				if (inv_stat.done)
					state_n = inv_stat.ok ? ST_MUL_DBL : ST_FINISH;
			end
			ST_FINISH: begin
				if (!m_tvalid_q || m_tready)
					state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		accept    = s_tready && s_tvalid;
		inv_start = (state_q == ST_DISPATCH) && (func_q == FUNC_DIV) && (rb_q != '0);
		out_load  = (state_q == ST_FINISH) && (!m_tvalid_q || m_tready);
		cfg_ready = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_q     <= MOD_RST;
		end else begin
			state_q <= state_n;
			if (cfg_valid)
				m_q <= cfg_data;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					func_q   <= s_tdata[FUNC_LSB +: FUNC_WIDTH];
					neg_q    <= a_in[A_WIDTH-1];
					div_q    <= a_mag;
					b_in_q   <= s_tdata[B_LSB +: B_WIDTH];
					rem_q    <= '0;
					cnt_q    <= CNT_W'(A_WIDTH - 1);
					ra_q     <= '0;
					rb_q     <= '0;
					acc_q    <= '0;
					// modulus zero or one: the result reads 0, divide sees zero divisor
					status_q <= (small_mod && s_tdata[FUNC_LSB +: FUNC_WIDTH] == FUNC_DIV)
						? STATUS_DIV_ZERO : STATUS_OK;
				end
			end
			ST_RED_A: begin
				rem_q <= mod_out;
				div_q <= div_q << 1;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			ST_FIX_A: begin
				// negative operand: fold the remainder back into range
				ra_q  <= (neg_q && rem_q != '0) ? (m_q - rem_q) : rem_q;
				rem_q <= '0;
				div_q <= {b_in_q, {B_PAD{1'b0}}};
				cnt_q <= CNT_W'(B_WIDTH - 1);
			end
			ST_RED_B: begin
				rem_q <= mod_out;
				div_q <= div_q << 1;
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0)
					rb_q <= mod_out;
			end
			ST_DISPATCH: begin
				case (func_q)
					FUNC_ADD: acc_q <= mod_out;
					FUNC_SUB: acc_q <= ra_q - rb_q;
					FUNC_MUL: begin
						x_q   <= rb_q;
						acc_q <= '0;
						cnt_q <= CNT_W'(W - 1);
					end
					FUNC_DIV: begin
						acc_q <= '0;
						if (rb_q == '0)
							status_q <= STATUS_DIV_ZERO;
					end
					default: acc_q <= ra_q;
				endcase
			end
			ST_SUB_FIX: begin
				if (ra_q < rb_q)
					acc_q <= acc_q + m_q;
			end
			ST_MUL_DBL: begin
				acc_q <= mod_out;
			end
			ST_MUL_ADD: begin
				if (x_q[cnt_q[IDX_W-1:0]])
					acc_q <= mod_out;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			ST_INV_WAIT: begin
				if (inv_stat.done) begin
					acc_q <= '0;
					x_q   <= inv_val;
					cnt_q <= CNT_W'(W - 1);
					if (!inv_stat.ok)
						status_q <= STATUS_NO_INV;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// result beat packing
	always_comb begin
		out_data                      = '0;
		out_data[W-1:0]               = acc_q;
		out_data[W]                   = (ra_q == rb_q);
		out_data[W+1]                 = (ra_q < rb_q);
		out_data[W+2 +: STATUS_W]     = status_q;
	end

	// output register parts the result from the next item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (out_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			m_tdata_q <= out_data;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// equal and less-than flags exclude each other
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[W] && m_tdata[W+1]))
		else $error("equal and less-than flags both set");

	// an error status always carries a zero result
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[W+2 +: STATUS_W] != STATUS_OK) |-> (m_tdata[W-1:0] == '0))
		else $error("nonzero result with error status");

	// results stay inside the field
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !small_mod) |-> (m_tdata[W-1:0] < m_q))
		else $error("result not reduced");

	// one item at a time: input closes right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while busy");

endmodule
`default_nettype wire
